FILE: rtl/pfa_pkg.sv
package pfa_pkg;

    localparam int MAX_HOLES = 2048;
    localparam int HOLE_AW   = $clog2(MAX_HOLES);
    localparam int CNT_W     = $clog2(MAX_HOLES + 1);
    localparam int PAGE_W    = 20;
    localparam int OFF_W     = 16;
    localparam int TOP_W     = 17;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [TOP_W-1:0] OFFSET_LIMIT = TOP_W'(65536);
    localparam logic [CNT_W-1:0] HOLE_LIMIT   = CNT_W'(MAX_HOLES);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic               we;
        logic [HOLE_AW-1:0] waddr;
        logic [OFF_W-1:0]   wdata;
        logic               re;
        logic [HOLE_AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number_out;
        t_status           status;
    } t_result;

endpackage

FILE: rtl/pfa_req_if.sv
interface pfa_req_if;
    import pfa_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output mode, output page_number, input ready);
    modport sink   (input valid, input mode, input page_number, output ready);
endinterface

FILE: rtl/pfa_rsp_if.sv
interface pfa_rsp_if;
    import pfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [PAGE_W-1:0]   page_number_out;
    logic [STAT_W-1:0]   status;

    modport source (output valid, output page_number_out, output status, input ready);
    modport sink   (input valid, input page_number_out, input status, output ready);
endinterface

FILE: rtl/pfa_hole_mem.sv
module pfa_hole_mem (
    input  logic                   i_clk,
    input  pfa_pkg::t_mem_req      i_req,
    output logic [pfa_pkg::OFF_W-1:0] o_rdata
);
    import pfa_pkg::*;

    logic [OFF_W-1:0] r_mem [MAX_HOLES];
    logic [OFF_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pfa_engine.sv
module pfa_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pfa_pkg::PAGE_W-1:0] i_base_page,
    input  logic [pfa_pkg::TOP_W-1:0]  i_region_pages,
    pfa_req_if.sink                    i_req,
    output pfa_pkg::t_result           o_res,
    output logic                       o_res_valid,
    input  logic                       i_res_ready
);
    import pfa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POP  = 5'b00010,
        S_LOW  = 5'b00100,
        S_INS  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TOP_W-1:0]  r_top, n_top;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [PAGE_W-1:0] r_pg, n_pg;
    t_status           r_st, n_st;

    t_mem_req          mem_req;
    logic [OFF_W-1:0]  rdata;

    logic [TOP_W-1:0]  region_eff;
    logic [PAGE_W-1:0] off_full;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  pos_m1;
    logic [TOP_W-1:0]  top_m1;

    pfa_hole_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign region_eff = (i_region_pages > OFFSET_LIMIT) ? OFFSET_LIMIT : i_region_pages;
    assign off_full   = i_req.page_number - i_base_page;
    assign count_m1   = r_count - CNT_W'(1);
    assign pos_m1     = r_pos - CNT_W'(1);
    assign top_m1     = r_top - TOP_W'(1);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_res.page_number_out = r_pg;
    assign o_res.status          = r_st;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_top   = r_top;
        n_pos   = r_pos;
        n_off   = r_off;
        n_pg    = r_pg;
        n_st    = r_st;
        mem_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_pg    = '0;
                    n_st    = ST_OK;
                    n_state = S_FIN;
                    if (i_req.mode == MODE_ALLOC) begin
                        if (r_count != '0) begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = count_m1[HOLE_AW-1:0];
                            n_state       = S_POP;
                        end else if (r_top < region_eff) begin
                            n_pg  = i_base_page + PAGE_W'(r_top);
                            n_top = r_top + TOP_W'(1);
                        end else begin
                            n_st = ST_OOM;
                        end
                    end else if (off_full < PAGE_W'(r_top)) begin
                        n_off = off_full[OFF_W-1:0];
                        if (off_full[TOP_W-1:0] + TOP_W'(1) == r_top) begin
                            // page just below top: lower top, then coalesce holes
                            n_top = top_m1;
                            if (r_count != '0 && top_m1 != '0) begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = count_m1[HOLE_AW-1:0];
                                n_state       = S_LOW;
                            end
                        end else if (r_count >= HOLE_LIMIT) begin
                            n_st = ST_FULL;
                        end else if (r_count != '0) begin
                            n_pos         = r_count;
                            mem_req.re    = 1'b1;
                            mem_req.raddr = count_m1[HOLE_AW-1:0];
                            n_state       = S_INS;
                        end else begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = '0;
                            mem_req.wdata = off_full[OFF_W-1:0];
                            n_count       = r_count + CNT_W'(1);
                        end
                    end
                end
            end
            S_POP: begin
                n_pg    = i_base_page + PAGE_W'(rdata);
                n_count = count_m1;
                n_state = S_FIN;
            end
            S_LOW: begin
                n_state = S_FIN;
                if (TOP_W'(rdata) + TOP_W'(1) == r_top) begin
                    n_count = count_m1;
                    n_top   = top_m1;
                    if (count_m1 != '0 && top_m1 != '0) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = HOLE_AW'(count_m1 - CNT_W'(1));
                        n_state       = S_LOW;
                    end
                end
            end
            S_INS: begin
                if (r_pos != '0 && rdata > r_off) begin
                    // shift the larger entry up one slot, read the next one down
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_pos[HOLE_AW-1:0];
                    mem_req.wdata = rdata;
                    n_pos         = pos_m1;
                    if (pos_m1 != '0) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = HOLE_AW'(pos_m1 - CNT_W'(1));
                    end
                end else begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_pos[HOLE_AW-1:0];
                    mem_req.wdata = r_off;
                    n_count       = r_count + CNT_W'(1);
                    n_state       = S_FIN;
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_off <= n_off;
        r_pg  <= n_pg;
        r_st  <= n_st;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HOLE_LIMIT)
        else $error("hole count above table size");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= OFFSET_LIMIT)
        else $error("top beyond offset range");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("hole table read and write hit the same entry");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_count < HOLE_LIMIT && r_pos <= r_count))
        else $error("insertion without room");

endmodule

FILE: rtl/page_frame_allocator_top.sv
// Channel  Dir  Handshake       Payload
// i_req    in   valid/ready     mode, page_number
// o_rsp    out  valid/ready     page_number_out, status
// i_cfg_*  in   write enable    index 0 base_page, 1 region_pages
//
// One transaction at a time. Bump allocate, out of memory, ignored free, table-full
// and insertion into an empty table need no table read; popping a hole reads it first.
// Insertion shifts each hole above the new one up one slot; a free at top reads and
// merges the holes just below top, stopping at the first hole it reads and keeps.
// Synchronous active-low reset clears count, top and config registers, not the hole table.
// A stalled result waits in the output register; the engine holds the next one.
module page_frame_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pfa_req_if.sink                       i_req,
    pfa_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfa_pkg::PAGE_W-1:0]    i_cfg_data
);
    import pfa_pkg::*;

    logic [PAGE_W-1:0] r_base_page;
    logic [TOP_W-1:0]  r_region_pages;
    logic              r_out_valid;
    t_result           r_out;

    t_result           res;
    logic              res_valid;
    logic              res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_page    <= '0;
            r_region_pages <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_PAGE:    r_base_page    <= i_cfg_data;
                CFG_REGION_PAGES: r_region_pages <= i_cfg_data[TOP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pfa_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_base_page    (r_base_page),
        .i_region_pages (r_region_pages),
        .i_req          (i_req),
        .o_res          (res),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.page_number_out = r_out.page_number_out;
    assign o_rsp.status          = r_out.status;

endmodule

FILE: test/tb_page_frame_allocator_top.sv
module tb_page_frame_allocator_top;
    import pfa_pkg::*;

    // Tracks the allocator's hole table, top counter and registers, and holds the
    // replies still owed by the block, oldest first.
    class frame_ledger;
        logic [OFF_W-1:0]  holes [MAX_HOLES];
        int unsigned       hole_cnt;
        int unsigned       top_pg;
        logic [PAGE_W-1:0] base_pg;
        logic [TOP_W-1:0]  region_pg;
        t_result           due_grants[$];
        int                errors;
        int                n_grant;
        int                n_oom;
        int                n_full;
        int                n_free;

        function new();
            hole_cnt  = 0;
            top_pg    = 0;
            base_pg   = '0;
            region_pg = '0;
            errors    = 0;
            n_grant   = 0;
            n_oom     = 0;
            n_full    = 0;
            n_free    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAGE_W-1:0] data);
            if (idx == CFG_BASE_PAGE) begin
                base_pg = data;
            end else begin
                region_pg = data[TOP_W-1:0];
            end
        endfunction

        function void book_request(logic mode, logic [PAGE_W-1:0] page);
            t_result           r;
            int unsigned       lim;
            logic [PAGE_W-1:0] off20;
            int unsigned       off;
            int unsigned       pos;
            r.page_number_out = '0;
            r.status          = ST_OK;
            // hole offsets are 16 bits wide, so clamp the usable region
            lim = 32'((region_pg > OFFSET_LIMIT) ? OFFSET_LIMIT : region_pg);
            if (mode == MODE_ALLOC) begin
                if (hole_cnt > 0) begin
                    hole_cnt--;
                    r.page_number_out = base_pg + PAGE_W'(holes[hole_cnt]);
                    n_grant++;
                end else if (top_pg < lim) begin
                    r.page_number_out = base_pg + PAGE_W'(top_pg);
                    top_pg++;
                    n_grant++;
                end else begin
                    r.status = ST_OOM;
                    n_oom++;
                end
            end else begin
                n_free++;
                off20 = page - base_pg;
                off   = 32'(off20);
                if (off < top_pg) begin
                    if (off + 1 == top_pg) begin
                        // lower top, then absorb holes sitting just below it
                        top_pg--;
                        while (hole_cnt > 0 && top_pg > 0 &&
                               holes[hole_cnt-1] + 1 == top_pg) begin
                            hole_cnt--;
                            top_pg--;
                        end
                    end else if (hole_cnt >= MAX_HOLES) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        pos = hole_cnt;
                        while (pos > 0 && holes[pos-1] > off) begin
                            holes[pos] = holes[pos-1];
                            pos--;
                        end
                        holes[pos] = OFF_W'(off);
                        hole_cnt++;
                    end
                end
            end
            due_grants.push_back(r);
        endfunction

        function void match_response(logic [PAGE_W-1:0] page, logic [STAT_W-1:0] st);
            t_result want;
            if (due_grants.size() == 0) begin
                errors++;
                $display("%0t: reply with none outstanding: page %h status %0d",
                         $time, page, st);
                return;
            end
            want = due_grants.pop_front();
            if (page !== want.page_number_out) begin
                errors++;
                $display("%0t: page_number_out mismatch: expected %h, actual %h",
                         $time, want.page_number_out, page);
            end
            if (st !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, st);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [PAGE_W-1:0]    cfg_data;
    int                   send_idle;
    int                   recv_idle;
    frame_ledger          ledger = new();

    pfa_req_if req_ch ();
    pfa_rsp_if rsp_ch ();

    page_frame_allocator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            ledger.match_response(rsp_ch.page_number_out, rsp_ch.status);
        end
    end

    task automatic send(input logic mode, input logic [PAGE_W-1:0] page);
        while ($urandom_range(0, 99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= mode;
        req_ch.page_number <= page;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        ledger.book_request(mode, page);
    endtask

    // drop valid and wait for every owed reply
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (ledger.due_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [PAGE_W-1:0] base, input logic [PAGE_W-1:0] region);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BASE_PAGE;
        cfg_data <= base;
        @(posedge i_clk);
        ledger.write_reg(CFG_BASE_PAGE, base);
        cfg_idx  <= CFG_REGION_PAGES;
        cfg_data <= region;
        @(posedge i_clk);
        ledger.write_reg(CFG_REGION_PAGES, region);
        cfg_we <= 1'b0;
    endtask

    task automatic random_run(input int count);
        int unsigned       off;
        int                r;
        logic              m;
        logic [PAGE_W-1:0] pg;
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] region;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                settle();
                base = ($urandom_range(0, 7) == 0) ? 20'hFFFFF : PAGE_W'($urandom);
                case ($urandom_range(0, 9))
                    0: region = '0;
                    1: region = 20'd65536;
                    2: region = 20'hFFFFF;
                    default: region = PAGE_W'($urandom_range(1, 48));
                endcase
                configure(base, region);
            end
            m = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (m == MODE_ALLOC || ledger.top_pg == 0 || r < 10) begin
                pg = PAGE_W'($urandom);
            end else begin
                if (r < 35) begin
                    off = ledger.top_pg - 1;
                end else if (r < 90) begin
                    off = $urandom_range(0, ledger.top_pg - 1);
                end else begin
                    off = ledger.top_pg + $urandom_range(0, 3);
                end
                pg = ledger.base_pg + PAGE_W'(off);
            end
            send(m, pg);
        end
    endtask

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_BASE_PAGE;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= MODE_ALLOC;
        req_ch.page_number <= '0;
        send_idle = 37;
        recv_idle = 88;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty region straight out of reset
        send(MODE_ALLOC, '0);
        send(MODE_FREE, '0);
        settle();

        // region wrapping past the top of the page space
        configure(20'hFFFFE, 20'd5);
        repeat (5) send(MODE_ALLOC, '0);
        send(MODE_ALLOC, 20'hFFFFF);
        send(MODE_FREE, 20'h00000);
        send(MODE_FREE, 20'h00000);
        send(MODE_FREE, 20'hFFFFF);
        send(MODE_FREE, 20'h12345);
        send(MODE_FREE, 20'hFFFFD);
        send(MODE_ALLOC, '0);
        send(MODE_FREE, 20'h00002);
        send(MODE_FREE, 20'h00001);
        send(MODE_ALLOC, '0);
        settle();

        // oversized region, state carried over
        configure('0, 20'hFFFFF);
        send(MODE_ALLOC, '0);
        settle();
        configure('0, '0);
        send(MODE_ALLOC, '0);
        send(MODE_FREE, 20'h00002);
        send(MODE_FREE, 20'h7FFFF);
        settle();

        // build holes in descending order with a duplicate, then coalesce into top
        configure(20'h40000, 20'd24);
        while (ledger.hole_cnt > 0) send(MODE_ALLOC, '0);
        while (ledger.top_pg < 24) send(MODE_ALLOC, '0);
        for (int k = 19; k >= 0; k--) begin
            send(MODE_FREE, 20'h40000 + PAGE_W'(k));
        end
        send(MODE_FREE, 20'h40000 + 20'd5);
        send(MODE_FREE, 20'h40000 + 20'd23);
        send(MODE_FREE, 20'h40000 + 20'd21);
        send(MODE_FREE, 20'h40000 + 20'd22);
        send(MODE_FREE, 20'h40000 + 20'd20);

        random_run(380);
        settle();
        send_idle = 88;
        recv_idle = 37;
        random_run(380);
        settle();
        send_idle = 0;
        recv_idle = 0;
        random_run(380);

        settle();
        repeat (16) @(posedge i_clk);
        $display("Covered %0d grants, %0d out-of-memory replies, %0d frees (%0d dropped on a full table),",
                 ledger.n_grant, ledger.n_oom, ledger.n_free, ledger.n_full);
        $display("across wrapped, empty, oversized and random regions under mixed backpressure.");
        if (ledger.errors == 0 && ledger.due_grants.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
